[hw/rtl/vcfb_pkg.sv]
// ----------------------------------------------------------------------------
// Virtual channel flit buffer package
// Shared constants, request codes and the sequencer state type.
// ----------------------------------------------------------------------------
package vcfb_pkg;

   localparam int DEF_NUM_CHANNELS = 4;
   localparam int DEF_MAX_DEPTH    = 8;
   localparam int DEF_FLIT_BITS    = 64;

   localparam int FUNC_W     = 2;
   localparam int CHANNEL_W  = 2;
   localparam int FLIT_W     = 64;
   localparam int OCC_W      = 4;
   localparam int LIMIT_W    = 4;
   localparam int REQ_USER_W = FUNC_W + CHANNEL_W;
   localparam int RSP_DATA_W = 72;
   localparam int RSP_USER_W = 1;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;

   localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_PULL = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_RESP = 3'b100
   } state_type;

endpackage

[hw/rtl/virtual_channel_flit_buffer.sv]
// ----------------------------------------------------------------------------
// Virtual channel flit buffer
// A request is taken in ST_IDLE, which also reads the flit memory into a
// register; ST_READ registers the response word and ST_RESP shows it
// until the response side takes it. No new request is taken before then.
// Reset clears all fill counts and head pointers at once and sets the depth
// limit to eight; the flit memory itself is not cleared.
// ----------------------------------------------------------------------------
module virtual_channel_flit_buffer #(
   parameter int NUM_CHANNELS = vcfb_pkg::DEF_NUM_CHANNELS,
   parameter int MAX_DEPTH    = vcfb_pkg::DEF_MAX_DEPTH,
   parameter int FLIT_BITS    = vcfb_pkg::DEF_FLIT_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // Fields from bit 0: flit_in.
   input  logic [vcfb_pkg::FLIT_W-1:0]       req_tdata,
   // Fields from bit 0: func, channel.
   input  logic [vcfb_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // Fields from bit 0: flit_out, occupancy, full_res, empty_res, error.
   output logic [vcfb_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // Fields from bit 0: flit_valid.
   output logic [vcfb_pkg::RSP_USER_W-1:0]   rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [vcfb_pkg::LIMIT_W-1:0]      csr_data
);
   import vcfb_pkg::*;

   localparam int CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int SLOT_W  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int CNT_W   = $clog2(MAX_DEPTH + 1);
   localparam int SUM_W   = CNT_W + 1;
   localparam int LIM_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
   localparam int ENTRIES = NUM_CHANNELS * MAX_DEPTH;
   localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   state_type state_ff, state_in;
   logic [LIMIT_W-1:0] limit_ff;
   logic [CNT_W-1:0]   count_ff [NUM_CHANNELS];
   logic [SLOT_W-1:0]  head_ff  [NUM_CHANNELS];

   logic [FLIT_BITS-1:0] mem [ENTRIES];
   logic [FLIT_BITS-1:0] rdata_ff;
   logic [FLIT_BITS-1:0] push_flit_ff;
   logic                 fwd_ff, valid_ff, full_ff, empty_ff, err_ff;
   logic [OCC_W-1:0]     occ_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                 rsp_user_ff;

   logic [FUNC_W-1:0]    func;
   logic [CH_W-1:0]      ch_idx;
   logic [FLIT_BITS-1:0] flit;
   logic                 accept, ch_ok, is_push, is_pull, push_ok, pull_ok;
   logic [CNT_W-1:0]     cnt_cur, cnt_new;
   logic [SLOT_W-1:0]    head_cur, head_new, tail;
   logic [SUM_W-1:0]     tail_sum;
   logic [LIM_W-1:0]     lim;
   logic [ADDR_W-1:0]    wr_addr, rd_addr;
   logic [FLIT_BITS-1:0] flit_sel;

   assign func      = req_tuser[FUNC_W-1:0];
   assign ch_idx    = CH_W'(req_tuser[REQ_USER_W-1:FUNC_W]);
   assign flit      = req_tdata[FLIT_BITS-1:0];
   assign accept    = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign ch_ok     = 32'(req_tuser[REQ_USER_W-1:FUNC_W]) < NUM_CHANNELS;
   assign is_push   = (func == FUNC_PUSH);
   assign is_pull   = (func == FUNC_PULL);
   assign cnt_cur   = count_ff[ch_idx];
   assign head_cur  = head_ff[ch_idx];

   always_comb begin
      priority if (limit_ff == '0) begin
         lim = LIM_W'(1);
      end else if (32'(limit_ff) > MAX_DEPTH) begin
         lim = LIM_W'(MAX_DEPTH);
      end else begin
         lim = LIM_W'(limit_ff);
      end
   end

   assign push_ok = is_push && ch_ok && (LIM_W'(cnt_cur) < lim);
   assign pull_ok = is_pull && ch_ok && (cnt_cur != '0);

   always_comb begin
      tail_sum = SUM_W'(head_cur) + SUM_W'(cnt_cur);
      if (32'(tail_sum) >= MAX_DEPTH) begin
         tail_sum = tail_sum - SUM_W'(MAX_DEPTH);
      end
      tail = SLOT_W'(tail_sum);
      if (32'(head_cur) == MAX_DEPTH - 1) begin
         head_new = '0;
      end else begin
         head_new = head_cur + SLOT_W'(1);
      end
      priority if (push_ok) begin
         cnt_new = cnt_cur + CNT_W'(1);
      end else if (pull_ok) begin
         cnt_new = cnt_cur - CNT_W'(1);
      end else begin
         cnt_new = cnt_cur;
      end
   end

   assign wr_addr = ADDR_W'(int'(ch_idx) * MAX_DEPTH + int'(tail));
   assign rd_addr = ADDR_W'(int'(ch_idx) * MAX_DEPTH + int'(head_cur));

   always_ff @(posedge clock) begin
      if (accept && push_ok) begin
         mem[wr_addr] <= flit;
      end
      if (accept) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         push_flit_ff <= flit;
         fwd_ff       <= push_ok && (cnt_cur == '0);
         valid_ff     <= ch_ok && (is_pull ? pull_ok : (cnt_new != '0));
         occ_ff       <= ch_ok ? OCC_W'(cnt_new) : '0;
         full_ff      <= ch_ok && (LIM_W'(cnt_new) >= lim);
         empty_ff     <= !ch_ok || (cnt_new == '0);
         err_ff       <= !ch_ok || (is_push && !push_ok) || (is_pull && !pull_ok);
      end
      if (state_ff == ST_READ) begin
         rsp_data_ff <= {RSP_DATA_W'(0)} | {1'b0, err_ff, empty_ff, full_ff, occ_ff,
                                            FLIT_W'(valid_ff ? flit_sel : '0)};
         rsp_user_ff <= valid_ff;
      end
   end

   assign flit_sel = fwd_ff ? push_flit_ff : rdata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            count_ff[i] <= '0;
            head_ff[i]  <= '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_data;
         end
         if (accept && ch_ok) begin
            count_ff[ch_idx] <= cnt_new;
            if (pull_ok) begin
               head_ff[ch_idx] <= head_new;
            end
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign rsp_tvalid = (state_ff == ST_RESP);
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

[bench/tb_virtual_channel_flit_buffer.sv]
// ----------------------------------------------------------------------------
// Virtual channel flit buffer testbench
// Drives push, pull, peek and spare requests on all four channels through
// the request stream and checks every response word against a behavioral
// predictor of the per-channel flit queues. The depth limit is changed
// between phases, including out-of-range values and a limit lowered below
// the current fill. Both stream sides idle and stall at random, and one
// phase holds the response side off for a long stretch.
// ----------------------------------------------------------------------------
module tb_virtual_channel_flit_buffer;

   timeunit 1ns;
   timeprecision 1ps;

   import vcfb_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_PEEK  = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
   localparam int NUM_VC      = DEF_NUM_CHANNELS;
   localparam int SLOTS       = DEF_MAX_DEPTH;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;
   localparam int ITEMS_PER_PHASE = 88;

   typedef struct packed {
      logic [FLIT_W-1:0] flit;
      logic              valid;
      logic [OCC_W-1:0]  occupancy;
      logic              full;
      logic              empty;
      logic              error;
   } buffer_result_type;

   class flit_buffer_scoreboard;
      logic [FLIT_W-1:0] slots [NUM_VC][SLOTS];
      logic [2:0]        head [NUM_VC] = '{default: '0};
      int                fill [NUM_VC] = '{default: 0};
      logic [LIMIT_W-1:0] limit_reg = LIMIT_RESET;
      buffer_result_type expected_q [$];
      int mismatches = 0;
      int pushes = 0;
      int pulls = 0;
      int peeks = 0;
      int refused = 0;
      int full_seen = 0;

      function void set_limit(logic [LIMIT_W-1:0] value);
         limit_reg = value;
      endfunction

      function int outstanding();
         return expected_q.size();
      endfunction

      function void note_request(logic [FUNC_W-1:0] func, logic [CHANNEL_W-1:0] ch,
                                 logic [FLIT_W-1:0] flit);
         buffer_result_type r;
         int lim;
         int cnt;
         lim = (limit_reg < 1) ? 1 : (limit_reg > SLOTS) ? SLOTS : int'(limit_reg);
         cnt = fill[ch];
         r = '0;
         case (func)
            FUNC_PUSH: begin
               pushes++;
               if (cnt >= lim) begin
                  r.error = 1'b1;
               end else begin
                  slots[ch][(head[ch] + cnt) % SLOTS] = flit;
                  cnt++;
                  fill[ch] = cnt;
               end
               if (cnt > 0) begin
                  r.flit = slots[ch][head[ch]];
                  r.valid = 1'b1;
               end
            end
            FUNC_PULL: begin
               pulls++;
               if (cnt == 0) begin
                  r.error = 1'b1;
               end else begin
                  r.flit = slots[ch][head[ch]];
                  r.valid = 1'b1;
                  head[ch] = head[ch] + 3'd1;
                  cnt--;
                  fill[ch] = cnt;
               end
            end
            default: begin
               peeks++;
               if (cnt > 0) begin
                  r.flit = slots[ch][head[ch]];
                  r.valid = 1'b1;
               end
            end
         endcase
         r.occupancy = cnt[OCC_W-1:0];
         r.full = (cnt >= lim);
         r.empty = (cnt == 0);
         if (r.error) refused++;
         if (r.full) full_seen++;
         expected_q = {expected_q, r};
      endfunction

      function void compare(string field, logic [FLIT_W-1:0] want, logic [FLIT_W-1:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(logic [RSP_DATA_W-1:0] data, logic [RSP_USER_W-1:0] user);
         buffer_result_type e;
         if (expected_q.size() == 0) begin
            $error("response word %0h arrived with nothing expected", data);
            mismatches++;
            return;
         end
         e = expected_q[0];
         expected_q.delete(0);
         compare("flit_out", e.flit, data[63:0]);
         compare("flit_valid", 64'(e.valid), 64'(user[0]));
         compare("occupancy", 64'(e.occupancy), 64'(data[67:64]));
         compare("full_res", 64'(e.full), 64'(data[68]));
         compare("empty_res", 64'(e.empty), 64'(data[69]));
         compare("error", 64'(e.error), 64'(data[70]));
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [FLIT_W-1:0]      req_tdata = '0;
   logic [REQ_USER_W-1:0]  req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [RSP_USER_W-1:0]  rsp_tuser;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [LIMIT_W-1:0]     csr_data = '0;

   flit_buffer_scoreboard sb = new();
   int  send_gap_max = 0;
   int  recv_stall_max = 0;
   bit  hold_responses = 1'b0;
   int  limits_written = 0;

   always #2 clock = ~clock;

   virtual_channel_flit_buffer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   task automatic offer_request(input logic [FUNC_W-1:0] func,
                                input logic [CHANNEL_W-1:0] ch,
                                input logic [FLIT_W-1:0] flit);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= {ch, func};
      req_tdata <= flit;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(func, ch, flit);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sb.set_limit(value);
      limits_written++;
   endtask

   function automatic logic [FLIT_W-1:0] random_flit();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   initial begin : response_side
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = $urandom_range(0, recv_stall_max);
         if (hold_responses) begin
            stall = HOLD_CYCLES;
            hold_responses = 1'b0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         sb.check_response(rsp_tdata, rsp_tuser);
      end
   end

   initial begin : watchdog
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin : stimulus
      int phase_limits [8];
      int push_pct;
      int pick;
      logic [FUNC_W-1:0] func;
      phase_limits = '{1, 15, 0, 4, 15, 2, 8, 7};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_gap_max = 3;
      recv_stall_max = 3;
      write_limit(4'd8);
      offer_request(FUNC_PEEK, 2'd0, '1);
      offer_request(FUNC_PULL, 2'd1, '0);
      offer_request(FUNC_SPARE, 2'd2, '1);
      offer_request(FUNC_PUSH, 2'd3, '0);
      offer_request(FUNC_PUSH, 2'd3, '1);
      offer_request(FUNC_PUSH, 2'd3, 64'h5555_5555_5555_5555);
      offer_request(FUNC_PUSH, 2'd3, 64'hAAAA_AAAA_AAAA_AAAA);
      for (int i = 0; i < 4; i++) offer_request(FUNC_PUSH, 2'd3, random_flit());
      offer_request(FUNC_PUSH, 2'd3, '1);
      offer_request(FUNC_PEEK, 2'd3, '0);
      offer_request(FUNC_PUSH, 2'd0, '1);
      wait_idle();
      write_limit(4'd3);
      offer_request(FUNC_PUSH, 2'd3, random_flit());
      offer_request(FUNC_PULL, 2'd3, '0);
      offer_request(FUNC_SPARE, 2'd3, '0);
      offer_request(FUNC_PUSH, 2'd0, random_flit());
      offer_request(FUNC_PUSH, 2'd0, random_flit());
      offer_request(FUNC_PUSH, 2'd0, random_flit());
      offer_request(FUNC_PULL, 2'd0, '0);
      wait_idle();

      foreach (phase_limits[p]) begin
         write_limit(phase_limits[p][LIMIT_W-1:0]);
         case (p % 3)
            0: begin
               send_gap_max = 0;
               recv_stall_max = 0;
            end
            1: begin
               send_gap_max = 16;
               recv_stall_max = 16;
            end
            default: begin
               send_gap_max = $urandom_range(0, 1) ? 16 : 0;
               recv_stall_max = 16 - send_gap_max;
            end
         endcase
         if (p == 1) begin
            send_gap_max = 0;
            hold_responses = 1'b1;
         end
         push_pct = (p % 2 == 0) ? 60 : 35;
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < push_pct) func = FUNC_PUSH;
            else if (pick < 85) func = FUNC_PULL;
            else if (pick < 95) func = FUNC_PEEK;
            else func = FUNC_SPARE;
            offer_request(func, CHANNEL_W'($urandom_range(0, NUM_VC - 1)), random_flit());
         end
         wait_idle();
      end

      repeat (10) @(posedge clock);
      $display("Covered %0d requests: %0d pushes, %0d pulls, %0d peeks, %0d refused.",
               sb.pushes + sb.pulls + sb.peeks, sb.pushes, sb.pulls, sb.peeks, sb.refused);
      $display("%0d depth limit writes from 0 to 15, %0d full reports, one long response stall.",
               limits_written, sb.full_seen);
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
